// ----- design/rpd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpd_pkg: shared types and constants of the random permutation drawer
// widths of the pool, the draw counters and the serial remainder unit
// ----------------------------------------------------------------------------
package rpd_pkg;

    localparam int MAX_COUNT = 1024;
    localparam int POS_W     = $clog2(MAX_COUNT);
    localparam int CNT_W     = POS_W + 1;
    localparam int CFG_W     = 11;
    localparam int WORD_W    = 31;
    localparam int BITCNT_W  = $clog2(WORD_W);
    localparam int LANES     = 4;
    localparam int LANE_W    = $clog2(LANES);
    localparam int ROWS      = MAX_COUNT / LANES;
    localparam int ROW_W     = POS_W - LANE_W;

    typedef logic [LANES-1:0][POS_W-1:0] row_t;

    typedef struct packed {
        logic [ROW_W-1:0] rd_row;
        logic             wr_en;
        logic [ROW_W-1:0] wr_row;
        row_t             wr_data;
        logic             clear;
    } pool_req_t;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_DIV     = 5'b00010,
        ST_RD_TAIL = 5'b00100,
        ST_RD_IDX  = 5'b01000,
        ST_WRITE   = 5'b10000
    } draw_state_t;

    // row contents when the pool holds the identity
    function automatic row_t identity_row(input logic [ROW_W-1:0] row);
        row_t r;
        for (int j = 0; j < LANES; j++)
        begin
            r[j] = {row, LANE_W'(j)};
        end
        return r;
    endfunction

endpackage

// ----- design/rpd_mod_serial.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpd_mod_serial: bit-serial remainder unit
// restoring remainder of the random word by the live pool size, one bit a cycle
// ----------------------------------------------------------------------------
module rpd_mod_serial (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [rpd_pkg::WORD_W-1:0] word,
    input  logic [rpd_pkg::CNT_W-1:0]  divisor,
    output logic                      done,
    output logic [rpd_pkg::CNT_W-1:0]  remainder
);
    import rpd_pkg::*;

    logic                busy_reg;
    logic                done_reg;
    logic [BITCNT_W-1:0] cnt_reg;
    logic [WORD_W-1:0]   word_reg;
    logic [CNT_W-1:0]    rem_reg;
    logic [CNT_W-1:0]    rem_next;
    logic [CNT_W-1:0]    div_reg;
    logic [CNT_W:0]      trial;
    logic [CNT_W:0]      diff;

    // shift the next word bit into the partial remainder
    assign trial = {rem_reg, word_reg[WORD_W-1]};
    assign diff  = trial - {1'b0, div_reg};

    always_comb
    begin
        if (trial >= {1'b0, div_reg})
        begin
            rem_next = diff[CNT_W-1:0];
        end
        else
        begin
            rem_next = trial[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= BITCNT_W'(WORD_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            word_reg <= word;
            div_reg  <= divisor;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            word_reg <= {word_reg[WORD_W-2:0], 1'b0};
            rem_reg  <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ----- design/rpd_pool.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpd_pool: free position pool
// row memory with one valid bit per row; an invalid row reads as the identity
// ----------------------------------------------------------------------------
module rpd_pool (
    input  logic               clk,
    input  logic               rst_n,
    input  rpd_pkg::pool_req_t req,
    output rpd_pkg::row_t      rd_data
);
    import rpd_pkg::*;

    row_t             mem [ROWS];
    row_t             mem_q_reg;
    logic [ROWS-1:0]  valid_reg;
    logic             rd_valid_reg;
    logic [ROW_W-1:0] rd_row_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_row] <= req.wr_data;
        end
        mem_q_reg  <= mem[req.rd_row];
        rd_row_reg <= req.rd_row;
    end

    // clear wins over a write in the same cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[req.rd_row];
            if (req.clear)
            begin
                valid_reg <= '0;
            end
            else if (req.wr_en)
            begin
                valid_reg[req.wr_row] <= 1'b1;
            end
        end
    end

    assign rd_data = rd_valid_reg ? mem_q_reg : identity_row(rd_row_reg);

endmodule

// ----- design/random_permutation_drawer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// random_permutation_drawer: Fisher-Yates permutation drawer
// one draw per input transaction, pool of free positions in a row memory
// ----------------------------------------------------------------------------
// Each input transaction carries a 31-bit random word. The word is reduced
// modulo the number of positions still free (plain modulo, no bias
// correction) by a bit-serial remainder unit, the free position at that
// index is reported with the draw rank, and the pool entry is replaced by
// the last live entry. A draw runs from acceptance to the result register
// through the remainder unit (one word bit per cycle), its done flag and
// the pool row memory accesses (tail read, index read, write back). The
// input is ready again in the cycle after the write back; while a draw is
// in progress no new word is taken. A new transaction is taken as soon
// as the draw is written back, even while the previous result still
// waits on the output; a draw that reaches write back while a result
// still waits holds there until the output frees up. perm_count of 0
// acts as 1, above 1024 acts as 1024. Any write to perm_count restarts
// the permutation. After reset and after each last draw the pool reads
// as the identity at once (row valid bits), with no clearing pass.
// ----------------------------------------------------------------------------
module random_permutation_drawer (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [30:0] rand_word, [31] zero
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [9:0] slot_position, [19:10] draw_rank, [23:20] zero
    output logic        m_axis_tlast,   // last_draw
    // configuration
    input  logic        cfg_wr_en,
    input  logic [10:0] cfg_wr_data     // perm_count
);
    import rpd_pkg::*;

    draw_state_t      state_reg;
    draw_state_t      state_next;
    logic [CFG_W-1:0] perm_count_reg;
    logic [CNT_W-1:0] draws_done_reg;
    logic [CNT_W-1:0] live_count;
    logic [CNT_W-1:0] rem_count;
    logic [CNT_W-1:0] tail_wide;
    logic [POS_W-1:0] tail_idx;
    logic [POS_W-1:0] draw_idx;
    logic [POS_W-1:0] tail_val_reg;
    logic [POS_W-1:0] pos_val;
    logic             in_fire;
    logic             out_free;
    logic             commit;
    logic             last_draw;
    logic             div_done;
    logic [CNT_W-1:0] div_rem;
    pool_req_t        pool_req;
    row_t             pool_rd;
    row_t             merged_row;

    // result register
    logic             m_valid_reg;
    logic [POS_W-1:0] m_slot_reg;
    logic [POS_W-1:0] m_rank_reg;
    logic             m_last_reg;

    // live pool size, clamped to 1..MAX_COUNT
    always_comb
    begin
        if (perm_count_reg == '0)
        begin
            live_count = CNT_W'(1);
        end
        else if (CNT_W'(perm_count_reg) > CNT_W'(MAX_COUNT))
        begin
            live_count = CNT_W'(MAX_COUNT);
        end
        else
        begin
            live_count = CNT_W'(perm_count_reg);
        end
    end

    assign rem_count = live_count - draws_done_reg;
    assign tail_wide = rem_count - 1'b1;
    assign tail_idx  = tail_wide[POS_W-1:0];
    assign draw_idx  = div_rem[POS_W-1:0];
    assign last_draw = (draws_done_reg + 1'b1) == live_count;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign commit        = (state_reg == ST_WRITE) && out_free;

    rpd_mod_serial u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_fire),
        .word      (s_axis_tdata[WORD_W-1:0]),
        .divisor   (rem_count),
        .done      (div_done),
        .remainder (div_rem)
    );

    // picked position and the row with the tail value swapped in
    always_comb
    begin
        pos_val    = pool_rd[draw_idx[LANE_W-1:0]];
        merged_row = pool_rd;
        merged_row[draw_idx[LANE_W-1:0]] = tail_val_reg;
    end

    // pool access: tail row first, then the drawn row, written back in place
    always_comb
    begin
        pool_req.rd_row  = draw_idx[POS_W-1:LANE_W];
        if (state_reg == ST_RD_TAIL)
        begin
            pool_req.rd_row = tail_idx[POS_W-1:LANE_W];
        end
        pool_req.wr_en   = commit;
        pool_req.wr_row  = draw_idx[POS_W-1:LANE_W];
        pool_req.wr_data = merged_row;
        pool_req.clear   = cfg_wr_en || (commit && last_draw);
    end

    rpd_pool u_pool (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (pool_req),
        .rd_data (pool_rd)
    );

    // draw sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_RD_TAIL;
                end
            end
            ST_RD_TAIL:
            begin
                state_next = ST_RD_IDX;
            end
            ST_RD_IDX:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            perm_count_reg <= CFG_W'(16);
            draws_done_reg <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                // new count restarts the permutation
                perm_count_reg <= cfg_wr_data;
                draws_done_reg <= '0;
            end
            else if (commit)
            begin
                if (last_draw)
                begin
                    draws_done_reg <= '0;
                end
                else
                begin
                    draws_done_reg <= draws_done_reg + 1'b1;
                end
            end
            if (commit)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_RD_IDX)
        begin
            tail_val_reg <= pool_rd[tail_idx[LANE_W-1:0]];
        end
        if (commit)
        begin
            m_slot_reg <= pos_val;
            m_rank_reg <= draws_done_reg[POS_W-1:0];
            m_last_reg <= last_draw;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {4'b0000, m_rank_reg, m_slot_reg};
    assign m_axis_tlast  = m_last_reg;

endmodule
